[sv/vital_sign_average_alarm_assert.svh]
// Assertion macros for the vital sign average alarm block.
// Used by the top level; needs clk_i and rst_ni in scope where expanded.
`ifndef VITAL_SIGN_AVERAGE_ALARM_ASSERT_SVH
`define VITAL_SIGN_AVERAGE_ALARM_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define VSA_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Trigger in one cycle implies the consequence in the next.
`define VSA_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

// Trigger implies the consequence in the same cycle.
`define VSA_ASSERT_IMPLIES(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cons)) \
    else $error(msg);

`endif

[sv/vsa_pkg.sv]
// Shared types and constants for the vital sign average alarm block.
// No dependencies; imported by every module of the block.
`default_nettype none

package vsa_pkg;

  // Field widths
  localparam int TEMP_W  = 16;
  localparam int ACCEL_W = 12;
  localparam int RATE_W  = 12;
  localparam int OXY_W   = 11;
  localparam int TIME_W  = 32;
  localparam int THR_W   = 24;
  localparam int SQ_W    = 2 * ACCEL_W;

  // Default ring depth
  localparam int WINDOW_DEF = 10;

  // One ring word holds both readings: {oxygen, rate}
  localparam int RING_W = RATE_W + OXY_W;

  // Stream word widths
  localparam int IN_BITS      = TEMP_W + 3 * ACCEL_W + RATE_W + OXY_W + TIME_W;
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS     = RATE_W + OXY_W + 5;
  localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP_LIMIT   = 3'd0,
    CFG_RATE_LOW     = 3'd1,
    CFG_RATE_HIGH    = 3'd2,
    CFG_OXYGEN_LOW   = 3'd3,
    CFG_STILL_THR_SQ = 3'd4,
    CFG_STILL_TMO_MS = 3'd5
  } cfg_reg_e;

  // Reset values of the registers
  localparam logic [TEMP_W-1:0] TEMP_LIMIT_RST = 16'd3850;
  localparam logic [RATE_W-1:0] RATE_LOW_RST   = 12'd800;
  localparam logic [RATE_W-1:0] RATE_HIGH_RST  = 12'd1920;
  localparam logic [OXY_W-1:0]  OXY_LOW_RST    = 11'd640;
  localparam logic [THR_W-1:0]  STILL_THR_RST  = 24'd5898;
  localparam logic [TIME_W-1:0] STILL_TMO_RST  = 32'd15000;

  typedef struct packed {
    logic [TEMP_W-1:0] temp_limit;
    logic [RATE_W-1:0] rate_low;
    logic [RATE_W-1:0] rate_high;
    logic [OXY_W-1:0]  oxygen_low;
    logic [THR_W-1:0]  still_thr_sq;
    logic [TIME_W-1:0] still_tmo_ms;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_DIV,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

[sv/vital_sign_average_alarm.sv]
// Top level of the vital sign average alarm block.
// Depends on vsa_pkg, vsa_ring, vsa_div, vsa_motion and the assert macro header.
`default_nettype none
`include "vital_sign_average_alarm_assert.svh"

// Takes one sensor report word and returns one result word. Heart rate and
// oxygen saturation go into a ring RAM of the last WINDOW readings (one word
// per slot, registered read) with running sums; the averages are the sums
// divided by the number of readings held, truncated. Alerts: temperature
// above limit, average rate outside [rate_low, rate_high], average oxygen
// below limit, and inactivity (squared motion below threshold for longer
// than the timeout, modular ms time). One report is in flight at a time:
// take the word and read its slot, update the sums and write the slot, run
// the serial dividers until both are done, then load the output register,
// waiting there while a held-off result still fills it. A finished result
// waits in the output register while the next report is taken. No clearing
// pass after reset; unwritten ring slots read as zero through per-slot
// valid bits.
// Configuration writes take effect at the clock edge of cfg_we_i.
module vital_sign_average_alarm
  import vsa_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF  // ring depth, 1..64
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Input report stream
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // temperature[15:0], accel_x[27:16], accel_y[39:28], accel_z[51:40],
  // heart_rate[63:52], oxygen_sat[74:64], now_ms[106:75], zero pad
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // Result stream
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // avg_rate[11:0], avg_oxygen[22:12], temp_alert[23], rate_alert[24],
  // oxygen_alert[25], still_alert[26], any_alert[27], zero pad
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  // Register write port
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int AW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int RT_W  = RATE_W + $clog2(WINDOW);
  localparam int OT_W  = OXY_W + $clog2(WINDOW);

  // Input word field offsets
  localparam int AX_LSB  = TEMP_W;
  localparam int AY_LSB  = AX_LSB + ACCEL_W;
  localparam int AZ_LSB  = AY_LSB + ACCEL_W;
  localparam int HR_LSB  = AZ_LSB + ACCEL_W;
  localparam int OX_LSB  = HR_LSB + RATE_W;
  localparam int NOW_LSB = OX_LSB + OXY_W;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_limit   <= TEMP_LIMIT_RST;
      cfg_q.rate_low     <= RATE_LOW_RST;
      cfg_q.rate_high    <= RATE_HIGH_RST;
      cfg_q.oxygen_low   <= OXY_LOW_RST;
      cfg_q.still_thr_sq <= STILL_THR_RST;
      cfg_q.still_tmo_ms <= STILL_TMO_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_TEMP_LIMIT:   cfg_q.temp_limit   <= cfg_data_i[TEMP_W-1:0];
        CFG_RATE_LOW:     cfg_q.rate_low     <= cfg_data_i[RATE_W-1:0];
        CFG_RATE_HIGH:    cfg_q.rate_high    <= cfg_data_i[RATE_W-1:0];
        CFG_OXYGEN_LOW:   cfg_q.oxygen_low   <= cfg_data_i[OXY_W-1:0];
        CFG_STILL_THR_SQ: cfg_q.still_thr_sq <= cfg_data_i[THR_W-1:0];
        CFG_STILL_TMO_MS: cfg_q.still_tmo_ms <= cfg_data_i[TIME_W-1:0];
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------
  state_e state_q, state_d;
  logic   in_accept;
  logic   upd_en;
  logic   out_load;
  logic   rate_busy, oxy_busy;
  logic   out_valid_q;

  assign in_accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    upd_en        = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        // old slot contents on the RAM read port this cycle
        upd_en  = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (!rate_busy && !oxy_busy) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Captured report
  // ---------------------------------------------------------------------
  logic [TEMP_W-1:0]  temp_q;
  logic [ACCEL_W-1:0] ax_q, ay_q, az_q;
  logic [RATE_W-1:0]  rate_in_q;
  logic [OXY_W-1:0]   oxy_in_q;
  logic [TIME_W-1:0]  now_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      temp_q    <= s_axis_tdata[TEMP_W-1:0];
      ax_q      <= s_axis_tdata[AX_LSB +: ACCEL_W];
      ay_q      <= s_axis_tdata[AY_LSB +: ACCEL_W];
      az_q      <= s_axis_tdata[AZ_LSB +: ACCEL_W];
      rate_in_q <= s_axis_tdata[HR_LSB +: RATE_W];
      oxy_in_q  <= s_axis_tdata[OX_LSB +: OXY_W];
      now_q     <= s_axis_tdata[NOW_LSB +: TIME_W];
    end
  end

  // ---------------------------------------------------------------------
  // Ring RAM, running sums, slot pointer
  // ---------------------------------------------------------------------
  logic [RING_W-1:0] old_word;
  logic [RATE_W-1:0] old_rate;
  logic [OXY_W-1:0]  old_oxy;
  logic [AW-1:0]     ring_pos_q, ring_pos_d;
  logic              ring_full_q;
  logic              wrap;
  logic [CNT_W-1:0]  count;
  logic [RT_W-1:0]   rate_total_q, rate_total_d;
  logic [OT_W-1:0]   oxy_total_q, oxy_total_d;

  // Read at accept, data back in ST_UPD, write back in ST_UPD. Only one
  // report is in flight, so read and write of a slot never overlap.
  vsa_ring #(
    .DEPTH (WINDOW),
    .AW    (AW)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_accept),
    .rd_addr_i (ring_pos_q),
    .rd_data_o (old_word),
    .wr_en_i   (upd_en),
    .wr_addr_i (ring_pos_q),
    .wr_data_i ({oxy_in_q, rate_in_q})
  );

  assign old_rate = old_word[RATE_W-1:0];
  assign old_oxy  = old_word[RING_W-1:RATE_W];

  assign wrap       = ring_pos_q == AW'(WINDOW - 1);
  assign ring_pos_d = wrap ? '0 : ring_pos_q + AW'(1);
  // readings held after this one is written; never zero
  assign count      = (ring_full_q || wrap) ? CNT_W'(WINDOW)
                                            : CNT_W'(ring_pos_q) + CNT_W'(1);

  assign rate_total_d = rate_total_q - RT_W'(old_rate) + RT_W'(rate_in_q);
  assign oxy_total_d  = oxy_total_q - OT_W'(old_oxy) + OT_W'(oxy_in_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_pos_q   <= '0;
      ring_full_q  <= 1'b0;
      rate_total_q <= '0;
      oxy_total_q  <= '0;
    end else if (upd_en) begin
      ring_pos_q   <= ring_pos_d;
      ring_full_q  <= ring_full_q || wrap;
      rate_total_q <= rate_total_d;
      oxy_total_q  <= oxy_total_d;
    end
  end

  // ---------------------------------------------------------------------
  // Averages: two serial dividers started together
  // ---------------------------------------------------------------------
  logic [RT_W-1:0] rate_quot;
  logic [OT_W-1:0] oxy_quot;

  vsa_div #(
    .N (RT_W),
    .D (CNT_W)
  ) u_div_rate (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (upd_en),
    .dividend_i (rate_total_d),
    .divisor_i  (count),
    .busy_o     (rate_busy),
    .quot_o     (rate_quot)
  );

  vsa_div #(
    .N (OT_W),
    .D (CNT_W)
  ) u_div_oxy (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (upd_en),
    .dividend_i (oxy_total_d),
    .divisor_i  (count),
    .busy_o     (oxy_busy),
    .quot_o     (oxy_quot)
  );

  // ---------------------------------------------------------------------
  // Inactivity; result registered in the motion block, well before the
  // dividers finish
  // ---------------------------------------------------------------------
  logic still_alert;

  vsa_motion u_motion (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (upd_en),
    .accel_x_i    (ax_q),
    .accel_y_i    (ay_q),
    .accel_z_i    (az_q),
    .now_ms_i     (now_q),
    .thr_sq_i     (cfg_q.still_thr_sq),
    .timeout_ms_i (cfg_q.still_tmo_ms),
    .still_o      (still_alert)
  );

  // ---------------------------------------------------------------------
  // Alerts and output register
  // ---------------------------------------------------------------------
  logic [RATE_W-1:0]      avg_rate;
  logic [OXY_W-1:0]       avg_oxygen;
  logic                   temp_alert, rate_alert, oxygen_alert, any_alert;
  logic [OUT_TDATA_W-1:0] out_word;
  logic [OUT_TDATA_W-1:0] out_data_q;

  // the mean never exceeds the largest reading, so truncation is exact
  assign avg_rate     = rate_quot[RATE_W-1:0];
  assign avg_oxygen   = oxy_quot[OXY_W-1:0];
  assign temp_alert   = $signed(temp_q) > $signed(cfg_q.temp_limit);
  assign rate_alert   = (avg_rate < cfg_q.rate_low) || (avg_rate > cfg_q.rate_high);
  assign oxygen_alert = avg_oxygen < cfg_q.oxygen_low;
  assign any_alert    = temp_alert || rate_alert || oxygen_alert || still_alert;

  assign out_word = OUT_TDATA_W'({any_alert, still_alert, oxygen_alert, rate_alert,
                                  temp_alert, avg_oxygen, avg_rate});

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `VSA_ASSERT_NEXT(a_div_started, state_q == ST_UPD, rate_busy && oxy_busy,
                   "dividers not running after sum update")
  `VSA_ASSERT_NEXT(a_out_no_overwrite,
                   state_q == ST_OUT && out_valid_q && !m_axis_tready,
                   state_q == ST_OUT, "result loaded over a pending word")
  `VSA_ASSERT_ALWAYS(a_pos_range, ring_pos_q <= AW'(WINDOW - 1),
                     "ring pointer beyond window")
  `VSA_ASSERT_IMPLIES(a_count_nonzero, upd_en, count != '0,
                      "zero divisor at sum update")

endmodule

`default_nettype wire

[sv/vsa_ring.sv]
// Reading ring storage: one synchronous RAM word per slot, registered read.
// Per-slot valid bits make never-written slots read as zero. Uses vsa_pkg.
`default_nettype none

module vsa_ring
  import vsa_pkg::*;
#(
  parameter int DEPTH = WINDOW_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              rd_en_i,
  input  wire logic [AW-1:0]     rd_addr_i,
  output logic      [RING_W-1:0] rd_data_o,
  input  wire logic              wr_en_i,
  input  wire logic [AW-1:0]     wr_addr_i,
  input  wire logic [RING_W-1:0] wr_data_i
);

  logic [RING_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid_q;
  logic [RING_W-1:0] rdata_q;
  logic              rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rdata_q : '0;

endmodule

`default_nettype wire

[sv/vsa_div.sv]
// Restoring serial divider, one quotient bit per cycle.
// Uses vsa_pkg for RATE_W in the default width of N.
`default_nettype none

module vsa_div
  import vsa_pkg::*;
#(
  parameter int N = RATE_W + 4,
  parameter int D = 4
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [N-1:0] dividend_i,
  input  wire logic [D-1:0] divisor_i,
  output logic              busy_o,
  output logic      [N-1:0] quot_o
);

  localparam int CW = $clog2(N + 1);

  logic [N-1:0]  acc_q, acc_d;
  logic [D-1:0]  rem_q, rem_d;
  logic [D-1:0]  div_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic [D:0]    trial;
  logic [D:0]    diff;
  logic          ge;

  assign trial = {rem_q, acc_q[N-1]};
  assign ge    = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    rem_d = ge ? diff[D-1:0] : trial[D-1:0];
    if (N > 1) begin
      acc_d = {acc_q[N-2:0], ge};
    end else begin
      acc_d = N'(ge);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(N);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o = busy_q;
  assign quot_o = acc_q;

endmodule

`default_nettype wire

[sv/vsa_motion.sv]
// Inactivity detector: squared acceleration magnitude against a threshold,
// modular elapsed time since the last motion. Two stages. Uses vsa_pkg.
`default_nettype none

module vsa_motion
  import vsa_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic signed [ACCEL_W-1:0] accel_x_i,
  input  wire logic signed [ACCEL_W-1:0] accel_y_i,
  input  wire logic signed [ACCEL_W-1:0] accel_z_i,
  input  wire logic        [TIME_W-1:0]  now_ms_i,
  input  wire logic        [THR_W-1:0]   thr_sq_i,
  input  wire logic        [TIME_W-1:0]  timeout_ms_i,
  output logic                           still_o
);

  logic signed [SQ_W-1:0] prod_x, prod_y, prod_z;
  logic [SQ_W-2:0]        sq_x_q, sq_y_q, sq_z_q;
  logic [TIME_W-1:0]      now_s1_q;
  logic                   s1_valid_q;
  logic [SQ_W-1:0]        mag_sq;
  logic [TIME_W-1:0]      elapsed;
  logic [TIME_W-1:0]      last_motion_q;
  logic                   still_q;

  assign prod_x = accel_x_i * accel_x_i;
  assign prod_y = accel_y_i * accel_y_i;
  assign prod_z = accel_z_i * accel_z_i;

  // Squares are never negative; the top bit is always clear
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sq_x_q   <= prod_x[SQ_W-2:0];
      sq_y_q   <= prod_y[SQ_W-2:0];
      sq_z_q   <= prod_z[SQ_W-2:0];
      now_s1_q <= now_ms_i;
    end
  end

  assign mag_sq  = SQ_W'(sq_x_q) + SQ_W'(sq_y_q) + SQ_W'(sq_z_q);
  assign elapsed = now_s1_q - last_motion_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      last_motion_q <= '0;
      still_q       <= 1'b0;
    end else begin
      s1_valid_q <= start_i;
      if (s1_valid_q) begin
        if (mag_sq < thr_sq_i) begin
          still_q <= elapsed > timeout_ms_i;
        end else begin
          last_motion_q <= now_s1_q;
          still_q       <= 1'b0;
        end
      end
    end
  end

  assign still_o = still_q;

endmodule

`default_nettype wire

[dv/tb.sv]
// Self-checking bench for vital_sign_average_alarm: sensor report words in, alarm words out.
// Depends on vsa_pkg and the block's RTL; predicts each alarm word from its own copy of
// the rings, running sums, motion timer and registers.
`timescale 1ns / 1ps

module tb;
  import vsa_pkg::*;

  localparam int          RING_DEPTH     = WINDOW_DEF;
  localparam int          RAND_PER_PHASE = 150;
  localparam int          PHASES         = 7;
  localparam int          LONG_HOLD      = 400;   // receiver hold-off, cycles
  localparam int          SETTLE_CYCLES  = 40;    // quiet time after every alarm word is back
  localparam int unsigned CYCLE_LIMIT    = 1_000_000;

  // Register indexes past the end of the list; the block must ignore writes there
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(CFG_STILL_TMO_MS + 1);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

  // Input word fields, lowest bits last in the declaration
  typedef struct packed {
    logic        [TIME_W-1:0]  now_ms;
    logic        [OXY_W-1:0]   oxygen_sat;
    logic        [RATE_W-1:0]  heart_rate;
    logic signed [ACCEL_W-1:0] accel_z;
    logic signed [ACCEL_W-1:0] accel_y;
    logic signed [ACCEL_W-1:0] accel_x;
    logic signed [TEMP_W-1:0]  temperature;
  } report_t;

  // Output word fields
  typedef struct packed {
    logic               any_alert;
    logic               still_alert;
    logic               oxygen_alert;
    logic               rate_alert;
    logic               temp_alert;
    logic [OXY_W-1:0]   avg_oxygen;
    logic [RATE_W-1:0]  avg_rate;
  } alarm_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;

  vital_sign_average_alarm DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Predictor copy of the registers
  logic signed [TEMP_W-1:0] temp_limit_m  = TEMP_LIMIT_RST;
  logic [RATE_W-1:0]        rate_low_m    = RATE_LOW_RST;
  logic [RATE_W-1:0]        rate_high_m   = RATE_HIGH_RST;
  logic [OXY_W-1:0]         oxygen_low_m  = OXY_LOW_RST;
  logic [THR_W-1:0]         still_thr_m   = STILL_THR_RST;
  logic [TIME_W-1:0]        still_tmo_m   = STILL_TMO_RST;

  // Predictor copy of the window and motion state
  logic [RATE_W-1:0] rate_hist [RING_DEPTH] = '{default: '0};
  logic [OXY_W-1:0]  oxy_hist  [RING_DEPTH] = '{default: '0};
  int unsigned       rate_sum     = 0;
  int unsigned       oxy_sum      = 0;
  int unsigned       slot         = 0;
  bit                window_full  = 1'b0;
  logic [TIME_W-1:0] last_motion_m = '0;

  report_t     report_q[$];         // words waiting for the driver
  alarm_t      alarm_expect_q[$];   // predicted alarm words, oldest first
  int unsigned fail_count  = 0;
  int unsigned result_cnt  = 0;
  int unsigned cycle_count = 0;
  logic [TIME_W-1:0] walk_ms = '0;  // clock of the well-formed report stream

  // Pacing knobs, set by the sequence block
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int unsigned hold_asks = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic note_fail(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // Mostly no gap, some short ones, a few long ones
  function automatic int unsigned draw_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 120);
  endfunction

  // Advances the window and motion state by one report and returns the alarm word
  function automatic alarm_t predict_alarm(report_t r);
    alarm_t            res;
    int unsigned       held;
    longint            mag_sq;
    logic [TIME_W-1:0] elapsed;
    rate_sum = rate_sum - rate_hist[slot] + r.heart_rate;
    oxy_sum  = oxy_sum - oxy_hist[slot] + r.oxygen_sat;
    rate_hist[slot] = r.heart_rate;
    oxy_hist[slot]  = r.oxygen_sat;
    if (slot == RING_DEPTH - 1) begin
      slot = 0;
      window_full = 1'b1;
    end else begin
      slot++;
    end
    // partial window: divide by the readings held so far, current one included
    held = window_full ? RING_DEPTH : slot;
    res.avg_rate     = RATE_W'(rate_sum / held);
    res.avg_oxygen   = OXY_W'(oxy_sum / held);
    res.temp_alert   = r.temperature > temp_limit_m;
    res.rate_alert   = (res.avg_rate < rate_low_m) || (res.avg_rate > rate_high_m);
    res.oxygen_alert = res.avg_oxygen < oxygen_low_m;
    mag_sq = longint'(r.accel_x) * longint'(r.accel_x) +
             longint'(r.accel_y) * longint'(r.accel_y) +
             longint'(r.accel_z) * longint'(r.accel_z);
    res.still_alert = 1'b0;
    if (mag_sq < longint'(still_thr_m)) begin
      elapsed = r.now_ms - last_motion_m;   // modular ms
      res.still_alert = elapsed > still_tmo_m;
    end else begin
      last_motion_m = r.now_ms;
    end
    res.any_alert = res.temp_alert | res.rate_alert | res.oxygen_alert | res.still_alert;
    return res;
  endfunction

  // Random report: mostly a plausible stream with advancing time, some pure noise
  function automatic report_t make_report();
    report_t     r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      r.temperature = TEMP_W'($urandom());
      r.accel_x     = ACCEL_W'($urandom());
      r.accel_y     = ACCEL_W'($urandom());
      r.accel_z     = ACCEL_W'($urandom());
      r.heart_rate  = RATE_W'($urandom());
      r.oxygen_sat  = OXY_W'($urandom());
      r.now_ms      = $urandom();
      return r;
    end
    pick = $urandom_range(0, 99);
    if (pick < 80)      walk_ms += $urandom_range(0, 2000);
    else if (pick < 95) walk_ms += $urandom_range(2000, 20000);
    else                walk_ms += $urandom();
    r.now_ms = walk_ms;
    if ($urandom_range(0, 3) != 0) begin
      // small motion, under the default stillness bound
      r.accel_x = ACCEL_W'($urandom_range(0, 80)) - ACCEL_W'(40);
      r.accel_y = ACCEL_W'($urandom_range(0, 80)) - ACCEL_W'(40);
      r.accel_z = ACCEL_W'($urandom_range(0, 80)) - ACCEL_W'(40);
    end else begin
      r.accel_x = ACCEL_W'($urandom());
      r.accel_y = ACCEL_W'($urandom());
      r.accel_z = ACCEL_W'($urandom());
    end
    r.temperature = TEMP_W'($urandom_range(3500, 4000));
    r.heart_rate  = ($urandom_range(0, 9) == 0) ? RATE_W'($urandom())
                                                : RATE_W'($urandom_range(600, 2200));
    r.oxygen_sat  = ($urandom_range(0, 9) == 0) ? OXY_W'($urandom())
                                                : OXY_W'($urandom_range(500, 1700));
    return r;
  endfunction

  task automatic push_report(logic [TEMP_W-1:0] temp, logic [ACCEL_W-1:0] ax,
                             logic [ACCEL_W-1:0] ay, logic [ACCEL_W-1:0] az,
                             logic [RATE_W-1:0] rate, logic [OXY_W-1:0] oxy,
                             logic [TIME_W-1:0] now);
    report_t r;
    r.temperature = temp;
    r.accel_x     = ax;
    r.accel_y     = ay;
    r.accel_z     = az;
    r.heart_rate  = rate;
    r.oxygen_sat  = oxy;
    r.now_ms      = now;
    report_q.push_back(r);
  endtask

  // Register write; bits above the register width carry junk the block must drop
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] data;
    data = $urandom();
    case (idx)
      CFG_TEMP_LIMIT: begin
        data[TEMP_W-1:0] = value[TEMP_W-1:0];
        temp_limit_m = data[TEMP_W-1:0];
      end
      CFG_RATE_LOW: begin
        data[RATE_W-1:0] = value[RATE_W-1:0];
        rate_low_m = data[RATE_W-1:0];
      end
      CFG_RATE_HIGH: begin
        data[RATE_W-1:0] = value[RATE_W-1:0];
        rate_high_m = data[RATE_W-1:0];
      end
      CFG_OXYGEN_LOW: begin
        data[OXY_W-1:0] = value[OXY_W-1:0];
        oxygen_low_m = data[OXY_W-1:0];
      end
      CFG_STILL_THR_SQ: begin
        data[THR_W-1:0] = value[THR_W-1:0];
        still_thr_m = data[THR_W-1:0];
      end
      CFG_STILL_TMO_MS: begin
        data = value;
        still_tmo_m = data;
      end
      default: ;  // spare index, no register behind it
    endcase
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Wait until every queued report is taken and every alarm word is back;
  // sampled on the falling edge so the driver's updates have settled
  task automatic drain_results();
    while (report_q.size() != 0 || s_axis_tvalid || alarm_expect_q.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Driver: presents queued reports, random gaps between words unless tx_steady is set.
  // Each accepted word is run through the predictor right at the handshake.
  int unsigned gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      gap_left = 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid)
        alarm_expect_q.push_back(predict_alarm(report_t'(s_axis_tdata[IN_BITS-1:0])));
      if (gap_left != 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (report_q.size() != 0) begin
        s_axis_tdata  <= IN_TDATA_W'(report_q.pop_front());
        s_axis_tvalid <= 1'b1;
        gap_left = tx_steady ? 0 : draw_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: checks each alarm word against the oldest prediction and drives
  // tready with random stalls (none while rx_steady is set) plus the requested long hold-offs.
  int unsigned stall_left = 0;
  int unsigned hold_done  = 0;
  always @(posedge clk_i or negedge rst_ni) begin : rx_side
    alarm_t got;
    alarm_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = alarm_t'(m_axis_tdata[OUT_BITS-1:0]);
        result_cnt++;
        if (alarm_expect_q.size() == 0) begin
          note_fail($sformatf("word %0d: alarm word with no report pending", result_cnt));
        end else begin
          want = alarm_expect_q.pop_front();
          if (got.avg_rate !== want.avg_rate)
            note_fail($sformatf("word %0d: avg_rate exp %0d got %0d",
                                result_cnt, want.avg_rate, got.avg_rate));
          if (got.avg_oxygen !== want.avg_oxygen)
            note_fail($sformatf("word %0d: avg_oxygen exp %0d got %0d",
                                result_cnt, want.avg_oxygen, got.avg_oxygen));
          if (got.temp_alert !== want.temp_alert)
            note_fail($sformatf("word %0d: temp_alert exp %b got %b",
                                result_cnt, want.temp_alert, got.temp_alert));
          if (got.rate_alert !== want.rate_alert)
            note_fail($sformatf("word %0d: rate_alert exp %b got %b",
                                result_cnt, want.rate_alert, got.rate_alert));
          if (got.oxygen_alert !== want.oxygen_alert)
            note_fail($sformatf("word %0d: oxygen_alert exp %b got %b",
                                result_cnt, want.oxygen_alert, got.oxygen_alert));
          if (got.still_alert !== want.still_alert)
            note_fail($sformatf("word %0d: still_alert exp %b got %b",
                                result_cnt, want.still_alert, got.still_alert));
          if (got.any_alert !== want.any_alert)
            note_fail($sformatf("word %0d: any_alert exp %b got %b",
                                result_cnt, want.any_alert, got.any_alert));
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_done != hold_asks) begin
        // long hold-off: block fills its output register and stalls its input
        hold_done++;
        stall_left = LONG_HOLD - 1;
        m_axis_tready <= 1'b0;
      end else begin
        if (!rx_steady && $urandom_range(0, 2) == 0) stall_left = draw_gap();
        m_axis_tready <= (stall_left == 0);
      end
    end
  end

  // Stimulus sequence: directed reports under reset settings, then phases of
  // random reports, each behind a fresh set of register values.
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty window, zero readings, time zero: still but not yet timed out
    push_report(16'd0, 12'd0, 12'd0, 12'd0, 12'd0, 11'd0, 32'd0);
    // Field extremes; full-scale motion restarts the stillness timer
    push_report(16'h7FFF, 12'h800, 12'h800, 12'h800, 12'hFFF, 11'h7FF, 32'd100);
    push_report(16'h8000, 12'h7FF, 12'h7FF, 12'h7FF, 12'd0, 11'd0, 32'd200);
    // Temperature at the limit, stillness exactly at the timeout: no alerts from either
    push_report(16'd3850, 12'd0, 12'd0, 12'd0, 12'd1200, 11'd1000, 32'd15200);
    // One past both
    push_report(16'd3851, 12'd0, 12'd0, 12'd0, 12'd1200, 11'd1000, 32'd15201);
    // Magnitude one under the stillness bound, then exactly on it (counts as motion)
    push_report(16'd3700, 12'd76, 12'd11, 12'd0, 12'd1300, 11'd1100, 32'd20000);
    push_report(16'd3700, 12'd76, 12'd11, 12'd1, 12'd1300, 11'd1100, 32'd20001);
    // Time wrap: motion just before 2^32, stillness counted across the wrap
    push_report(16'd3700, 12'h800, 12'd0, 12'd0, 12'd1400, 11'd1200, 32'hFFFF_FF00);
    push_report(16'd3700, 12'd0, 12'd0, 12'd0, 12'd1400, 11'd1200, 32'h0000_3A00);
    push_report(16'd3700, 12'd0, 12'd0, 12'd0, 12'd1400, 11'd1200, 32'h0000_0010);
    // Wrap the ring with band-edge readings until the averages sit on the limits
    for (int i = 0; i < 11; i++)
      push_report(16'd3000, 12'd0, 12'd0, 12'd0, 12'd1920, 11'd640, 32'h20 + 32'(i) * 100);
    walk_ms = 32'h0000_2000;
    drain_results();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          // all minimums; zero bound means nothing is still
          cfg_write(CFG_TEMP_LIMIT,   32'h0000_8000);
          cfg_write(CFG_RATE_LOW,     32'd0);
          cfg_write(CFG_RATE_HIGH,    32'd0);
          cfg_write(CFG_OXYGEN_LOW,   32'd0);
          cfg_write(CFG_STILL_THR_SQ, 32'd0);
          cfg_write(CFG_STILL_TMO_MS, 32'd0);
          cfg_write(CFG_SPARE_LO,     $urandom());
          cfg_write(CFG_SPARE_HI,     $urandom());
        end
        1: begin
          cfg_write(CFG_TEMP_LIMIT,   32'h0000_7FFF);
          cfg_write(CFG_RATE_LOW,     32'hFFF);
          cfg_write(CFG_RATE_HIGH,    32'hFFF);
          cfg_write(CFG_OXYGEN_LOW,   32'h7FF);
          cfg_write(CFG_STILL_THR_SQ, 32'hFF_FFFF);
          cfg_write(CFG_STILL_TMO_MS, 32'hFFFF_FFFF);
        end
        default: begin
          cfg_write(CFG_TEMP_LIMIT, $urandom_range(0, 1) ? $urandom_range(3500, 4000)
                                                        : $urandom());
          cfg_write(CFG_RATE_LOW,   $urandom_range(0, 1) ? $urandom_range(400, 1200)
                                                        : $urandom());
          cfg_write(CFG_RATE_HIGH,  $urandom_range(0, 1) ? $urandom_range(1200, 3000)
                                                        : $urandom());
          cfg_write(CFG_OXYGEN_LOW, $urandom_range(0, 1) ? $urandom_range(300, 1700)
                                                        : $urandom());
          cfg_write(CFG_STILL_THR_SQ, $urandom_range(0, 1) ? $urandom_range(0, 20000)
                                                          : $urandom());
          cfg_write(CFG_STILL_TMO_MS, $urandom_range(0, 1) ? $urandom_range(0, 30000)
                                                          : $urandom());
          if (ph == 3) begin
            cfg_write(CFG_SPARE_HI, $urandom());
            walk_ms = 32'hFFFF_0000;   // let the report clock roll over
          end
        end
      endcase

      tx_steady = (ph == 2 || ph == 5);
      rx_steady = (ph == 5);
      if (ph == 2) hold_asks++;        // sender keeps offering during the hold

      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        if (ph == 4 && k == RAND_PER_PHASE / 2) drain_results();
        report_q.push_back(make_report());
      end
      drain_results();
    end

    if (fail_count == 0 && alarm_expect_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
